### design/oahs_pkg.sv
package oahs_pkg;

	localparam int KEY_W = 64;
	localparam int LEN_W = 4;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_FIND   = 2'd2,
		FN_LIST   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	localparam logic [1:0] FLAG_EMPTY   = 2'd0;
	localparam logic [1:0] FLAG_FILLED  = 2'd1;
	localparam logic [1:0] FLAG_DELETED = 2'd2;

	// one request word
	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] key_bytes;
		logic [LEN_W-1:0] key_len;
	} req_t;

	// one result word
	typedef struct packed {
		logic [1:0]       status;
		logic             found;
		logic [5:0]       slot;
		logic [KEY_W-1:0] out_key_bytes;
		logic [LEN_W-1:0] out_key_len;
		logic [6:0]       element_count;
		logic             entry_valid;
		logic             last;
	} rsp_t;

endpackage

### design/oahs_if.sv
interface oahs_req_if;
	logic              valid;
	logic              ready;
	oahs_pkg::req_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface oahs_rsp_if;
	logic              valid;
	logic              ready;
	oahs_pkg::rsp_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/open_address_hash_set.sv
// Hash set of short byte-string keys, linear probing with tombstones.
// Channels: req (sink) carries func, key_bytes, key_len; rsp (source) carries
// one result word per operation, or one word per filled slot for a list,
// with last marking the final word of the operation.
// cfg_we/cfg_wdata write table_size (probe modulus); the user must write it
// only while idle, as the block does not enforce this. Each operation first
// normalises and hashes the key, one byte a cycle plus a closing step, then
// reduces the hash modulo the table size by a restoring divider, one bit a
// cycle. A load step sets the start slot, then the probe visits one slot at a
// time, a read state then a compare state per slot, and writes back in the
// compare state. An output state moves the word to the output register.
// A list sweeps all table_size slots, a read state and a compare state per
// slot, then an output state for the final word.
// Reset: flags in flip-flops cleared to empty, count zero, table_size 64;
// the key memories are not cleared. No clearing pass is needed.
// When the receiver stalls, the word is held in the output register; the next
// request may be taken meanwhile, but its own words wait behind it.
module open_address_hash_set #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	oahs_req_if.sink   req,
	oahs_rsp_if.source rsp
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_MOD, S_READ, S_CMP, S_LREAD, S_LCMP, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] flags_q [TABLE_DEPTH];
	logic [63:0] keys_mem [TABLE_DEPTH];
	logic [3:0]  lens_mem [TABLE_DEPTH];
	logic [63:0] rd_key_q;
	logic [3:0]  rd_len_q;
	logic [1:0]  rd_flag_q;
	logic [6:0]  tsize_q;
	logic [CW-1:0] count_q;
	logic [1:0]  func_q;
	logic [63:0] raw_q, key_q;
	logic [3:0]  rlen_q, klen_q;
	logic        ended_q;
	logic [3:0]  bi_q;
	logic [31:0] hash_q;
	logic [6:0]  rem_q;
	logic [5:0]  bit_q;
	logic [AW-1:0] loc_q, tomb_at_q;
	logic        tomb_q;
	logic [6:0]  steps_q;
	logic        any_q;
	logic        pend_q;
	oahs_pkg::rsp_t hold_q;
	logic        rsp_valid_q;
	oahs_pkg::rsp_t rsp_q;

	// effective table size
	logic [6:0] n;
	always_comb begin
		if (tsize_q == 7'd0) n = 7'd1;
		else if (tsize_q > 7'(TABLE_DEPTH)) n = 7'(TABLE_DEPTH);
		else n = tsize_q;
	end

	logic [7:0] cur_byte;
	assign cur_byte = raw_q[{bi_q[2:0], 3'b000} +: 8];

	logic [7:0] rem_sh;
	assign rem_sh = {rem_q, hash_q[31]};

	logic [AW-1:0] loc_nx;
	assign loc_nx = (7'(loc_q) + 7'd1 >= n) ? '0 : AW'(7'(loc_q) + 7'd1);

	logic list_end;
	assign list_end = (7'(loc_q) + 7'd1 >= n);

	logic out_free;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// key store and flag read, registered
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	always_ff @(posedge clk) begin
		if (mem_we) begin
			keys_mem[mem_wa] <= key_q;
			lens_mem[mem_wa] <= klen_q;
		end
		rd_key_q <= keys_mem[mem_ra];
		rd_len_q <= lens_mem[mem_ra];
		rd_flag_q <= flags_q[mem_ra];
	end
	assign mem_ra = loc_q;

	function automatic oahs_pkg::rsp_t mk(logic [1:0] st, logic f, logic [5:0] sl,
			logic [63:0] k, logic [3:0] l, logic [6:0] c, logic v, logic la);
		oahs_pkg::rsp_t r;
		r.status = st; r.found = f; r.slot = sl; r.out_key_bytes = k;
		r.out_key_len = l; r.element_count = c; r.entry_valid = v; r.last = la;
		return r;
	endfunction

	// write-back decision in compare state
	logic [1:0] fl;
	logic       hit;
	assign fl  = rd_flag_q;
	assign hit = (fl == oahs_pkg::FLAG_FILLED) && (rd_len_q == klen_q) && (rd_key_q == key_q);
	assign mem_we = (state_q == S_CMP) && (func_q == oahs_pkg::FN_ADD) && !hit &&
		((fl == oahs_pkg::FLAG_EMPTY) ||
		 ((7'(steps_q) + 7'd1 >= n) && (tomb_q || fl == oahs_pkg::FLAG_DELETED)));
	assign mem_wa = (tomb_q) ? tomb_at_q : loc_q;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < TABLE_DEPTH; i++) flags_q[i] <= oahs_pkg::FLAG_EMPTY;
			tsize_q <= 7'd64;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cfg_we) tsize_q <= cfg_wdata;
			if (rsp_valid_q && rsp.ready && state_q != S_OUT) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						func_q <= req.data.func;
						raw_q <= req.data.key_bytes;
						rlen_q <= (req.data.key_len > 4'd8) ? 4'd8 : req.data.key_len;
						key_q <= '0; klen_q <= '0; ended_q <= 1'b0;
						bi_q <= '0; hash_q <= '0; loc_q <= '0;
						any_q <= 1'b0; pend_q <= 1'b0;
						state_q <= (req.data.func == oahs_pkg::FN_LIST) ? S_LREAD : S_HASH;
					end
				end
				S_HASH: begin
					if (bi_q >= rlen_q) begin
						state_q <= S_MOD; rem_q <= '0; bit_q <= '0;
					end else begin
						if (!ended_q && cur_byte != 8'd0) begin
							key_q[{bi_q[2:0], 3'b000} +: 8] <= cur_byte;
							klen_q <= klen_q + 4'd1;
							hash_q <= (hash_q << 5) - hash_q + 32'(cur_byte);
						end else ended_q <= 1'b1;
						bi_q <= bi_q + 4'd1;
					end
				end
				S_MOD: begin
					// restoring remainder, one hash bit a cycle
					hash_q <= hash_q << 1;
					rem_q <= (rem_sh >= {1'b0, n}) ? 7'(rem_sh - {1'b0, n}) : rem_sh[6:0];
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) state_q <= S_READ;
				end
				S_READ: begin
					if (bit_q == 6'd32) begin
						loc_q <= AW'(rem_q); bit_q <= '0; tomb_q <= 1'b0; steps_q <= '0;
					end else state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_OUT;
						case (func_q)
							oahs_pkg::FN_ADD:
								hold_q <= mk(oahs_pkg::ST_MISS, 1'b1, 6'(loc_q), '0, '0,
									7'(count_q), 1'b0, 1'b1);
							oahs_pkg::FN_REMOVE: begin
								flags_q[loc_q] <= oahs_pkg::FLAG_DELETED;
								count_q <= count_q - 1'b1;
								hold_q <= mk(oahs_pkg::ST_DONE, 1'b1, 6'(loc_q), '0, '0,
									7'(count_q - 1'b1), 1'b0, 1'b1);
							end
							default:
								hold_q <= mk(oahs_pkg::ST_DONE, 1'b1, 6'(loc_q), rd_key_q,
									rd_len_q, 7'(count_q), 1'b0, 1'b1);
						endcase
					end else if (fl == oahs_pkg::FLAG_EMPTY ||
							7'(steps_q) + 7'd1 >= n) begin
						state_q <= S_OUT;
						if (mem_we) begin
							flags_q[mem_wa] <= oahs_pkg::FLAG_FILLED;
							count_q <= count_q + 1'b1;
							hold_q <= mk(oahs_pkg::ST_DONE, 1'b0, 6'(mem_wa), '0, '0,
								7'(count_q + 1'b1), 1'b0, 1'b1);
						end else
							hold_q <= mk((func_q == oahs_pkg::FN_ADD) ? oahs_pkg::ST_FULL
								: oahs_pkg::ST_MISS, 1'b0, '0, '0, '0, 7'(count_q),
								1'b0, 1'b1);
					end else begin
						if (fl == oahs_pkg::FLAG_DELETED && !tomb_q) begin
							tomb_q <= 1'b1; tomb_at_q <= loc_q;
						end
						loc_q <= loc_nx; steps_q <= steps_q + 7'd1;
						state_q <= S_READ;
					end
				end
				S_LREAD: begin
					if (out_free || !pend_q) state_q <= S_LCMP;
				end
				S_LCMP: begin
					// a pending entry goes out when the next is known or the sweep ends
					if (fl == oahs_pkg::FLAG_FILLED) begin
						if (pend_q) begin
							rsp_q <= hold_q; rsp_valid_q <= 1'b1;
						end
						pend_q <= 1'b1; any_q <= 1'b1;
						hold_q <= mk(oahs_pkg::ST_DONE, 1'b1, 6'(loc_q), rd_key_q, rd_len_q,
							7'(count_q), 1'b1, list_end);
					end else if (list_end) begin
						if (any_q) hold_q.last <= 1'b1;
						else hold_q <= mk(oahs_pkg::ST_DONE, 1'b0, '0, '0, '0,
							7'(count_q), 1'b0, 1'b1);
					end
					if (list_end) state_q <= S_OUT;
					else begin
						loc_q <= loc_nx; state_q <= S_LREAD;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_q <= hold_q; rsp_valid_q <= 1'b1; pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a word is never overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result word lost under stall");
	// filled count never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("element count overflow");
	// no request taken while an operation runs
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready)
		else $error("request accepted mid operation");
	// probe stays inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> 7'(loc_q) < n)
		else $error("probe outside table");
endmodule
